### hdl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants of the mu-law rate codec
// Field widths, mu-law constants and the segment base table.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int unsigned RATE_RATIO_DEF = 2;

  localparam int unsigned PCM_W   = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned GAIN_W  = 5;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned DATA_W  = 24;
  localparam int unsigned IUSER_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 5'd4;

  // Item kinds, carried in tuser bit 0
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [14:0]       MU_BIAS     = 15'h0084;
  localparam logic [16:0]       MU_CLIP     = 17'd32635;
  localparam logic [CODE_W-1:0] MU_ZERO_SUB = 8'h02;
  localparam logic [3:0]        MANT_MASK   = 4'hF;

  localparam logic [19:0] SAT_POS = 20'd32767;
  localparam logic [19:0] SAT_NEG = 20'd32768;

  typedef logic [14:0] mag15_t;

  // Start of each mu-law segment, already biased out
  function automatic mag15_t seg_base(input logic [2:0] seg);
    mag15_t b;
    unique case (seg)
      3'd0: b = 15'd0;
      3'd1: b = 15'd132;
      3'd2: b = 15'd396;
      3'd3: b = 15'd924;
      3'd4: b = 15'd1980;
      3'd5: b = 15'd4092;
      3'd6: b = 15'd8316;
      3'd7: b = 15'd16764;
      default: b = 15'd0;
    endcase
    return b;
  endfunction

endpackage

### hdl/ulaw_rate_codec.sv
// ----------------------------------------------------------------------------
// ulaw_rate_codec: mu-law codec with sample-rate change
// The input register feeds the result register. Encode takes a sample every
// cycle unless the input is stalled; a decode item gives RATE_RATIO copies.
// Synchronous reset clears group sum, fill, valids, and sets the gain to 4.
// ----------------------------------------------------------------------------
module ulaw_rate_codec #(
  parameter int unsigned RATE_RATIO = urc_pkg::RATE_RATIO_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [urc_pkg::DATA_W-1:0] in_tdata,   // pcm_sample[15:0], code_byte[23:16]
  input  logic [urc_pkg::IUSER_W-1:0] in_tuser,  // kind[0], block_first[1]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [urc_pkg::DATA_W-1:0] out_tdata,  // code_out[7:0], pcm_out[23:8]
  output logic                       out_tuser,  // result_kind
  output logic                       out_tlast,  // last_copy
  input  logic                       cfg_we,
  input  logic [urc_pkg::GAIN_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W     = (RATE_RATIO > 1) ? $clog2(RATE_RATIO) : 1;
  localparam int unsigned DIV_SHIFT = 20;
  localparam int unsigned MUL_W     = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = urc_pkg::SUM_W + MUL_W;
  localparam int unsigned Q_W       = 17;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SHIFT) + RATE_RATIO - 1) / RATE_RATIO);
  localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(RATE_RATIO - 1);

  // Input fields
  logic                             in_kind;
  logic                             in_first;
  logic signed [urc_pkg::PCM_W-1:0] in_pcm;
  logic [urc_pkg::CODE_W-1:0]       in_code;
  logic                             in_acc;

  assign in_kind  = in_tuser[0];
  assign in_first = in_tuser[1];
  assign in_pcm   = signed'(in_tdata[15:0]);
  assign in_code  = in_tdata[23:16];
  assign in_acc   = in_tvalid && in_tready;

  // Configuration
  logic [urc_pkg::GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= urc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // Group accumulation happens as samples are taken in
  logic signed [urc_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_base, sum_add;
  logic [CNT_W-1:0]                 fill_r, fill_nxt, fill_base;
  logic                             grp_done;

  always_comb begin
    sum_base  = in_first ? '0 : sum_r;
    fill_base = in_first ? '0 : fill_r;
    sum_add   = sum_base + {{(urc_pkg::SUM_W - urc_pkg::PCM_W){in_pcm[15]}}, in_pcm};
    grp_done  = (fill_base == LAST_FILL);
    sum_nxt   = sum_r;
    fill_nxt  = fill_r;
    if (in_acc && in_kind == urc_pkg::KIND_ENCODE) begin
      if (grp_done) begin
        sum_nxt  = '0;
        fill_nxt = '0;
      end else begin
        sum_nxt  = sum_add;
        fill_nxt = fill_base + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Input register: completed group sums and decode bytes
  logic                             a_valid_r, a_valid_nxt;
  logic                             a_kind_r;
  logic signed [urc_pkg::SUM_W-1:0] a_sum_r;
  logic [urc_pkg::CODE_W-1:0]       a_code_r;
  logic                             a_load, a_adv;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r;
  logic [urc_pkg::CODE_W-1:0] out_code_r;
  logic [urc_pkg::PCM_W-1:0]  out_pcm_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       out_free;

  assign out_free  = !out_valid_r || (out_tready && cnt_r == '0);
  assign a_adv     = a_valid_r && out_free;
  assign in_tready = !a_valid_r || a_adv;
  assign a_load    = in_acc && (in_kind == urc_pkg::KIND_DECODE || grp_done);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = a_load;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_kind_r <= in_kind;
      a_sum_r  <= sum_add;
      a_code_r <= in_code;
    end
  end

  // Encode: magnitude, division by the ratio as a reciprocal multiply, mu-law
  logic                       sum_neg;
  logic [urc_pkg::SUM_W-1:0]  sum_mag;
  logic [PROD_W-1:0]          div_prod;
  logic [Q_W-1:0]             avg_mag, avg_clip;
  urc_pkg::mag15_t            mag_b;
  logic [2:0]                 enc_exp;
  logic [3:0]                 enc_mant;
  logic                       enc_sign;
  logic [urc_pkg::CODE_W-1:0] enc_raw, enc_code;

  always_comb begin
    sum_neg  = a_sum_r[urc_pkg::SUM_W-1];
    sum_mag  = sum_neg ? unsigned'(-a_sum_r) : unsigned'(a_sum_r);
    div_prod = PROD_W'(sum_mag) * PROD_W'(DIV_MUL);
    avg_mag  = div_prod[DIV_SHIFT +: Q_W];
    avg_clip = (avg_mag > urc_pkg::MU_CLIP) ? urc_pkg::MU_CLIP : avg_mag;
    mag_b    = avg_clip[14:0] + urc_pkg::MU_BIAS;
    // The average truncates toward zero, so a small negative sum has no sign
    enc_sign = sum_neg && (avg_mag != '0);
    enc_exp  = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mag_b[7 + i]) begin
        enc_exp = 3'(i);
      end
    end
    enc_mant = 4'(mag_b >> ({1'b0, enc_exp} + 4'd3)) & urc_pkg::MANT_MASK;
    enc_raw  = ~{enc_sign, enc_exp, enc_mant};
    enc_code = (enc_raw == '0) ? urc_pkg::MU_ZERO_SUB : enc_raw;
  end

  // Decode: expansion, gain and saturation
  logic [urc_pkg::CODE_W-1:0] dec_b;
  urc_pkg::mag15_t            dec_mag;
  logic [19:0]                dec_prod;
  logic [urc_pkg::PCM_W-1:0]  dec_pcm;

  always_comb begin
    dec_b    = ~a_code_r;
    dec_mag  = urc_pkg::seg_base(dec_b[6:4])
             + (15'(dec_b[3:0]) << ({1'b0, dec_b[6:4]} + 4'd3));
    dec_prod = 20'(dec_mag) * 20'(gain_r);
    if (dec_b[7]) begin
      dec_pcm = (dec_prod > urc_pkg::SAT_NEG) ? 16'h8000 : 16'(-dec_prod);
    end else begin
      dec_pcm = (dec_prod > urc_pkg::SAT_POS) ? 16'h7FFF : dec_prod[15:0];
    end
  end

  // Result register, repeating a decoded sample RATE_RATIO times
  always_comb begin
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    if (a_adv) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = (a_kind_r == urc_pkg::KIND_DECODE) ? LAST_FILL : '0;
    end else if (out_valid_r && out_tready) begin
      if (cnt_r == '0) begin
        out_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_kind_r <= a_kind_r;
      if (a_kind_r == urc_pkg::KIND_DECODE) begin
        out_code_r <= '0;
        out_pcm_r  <= dec_pcm;
      end else begin
        out_code_r <= enc_code;
        out_pcm_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pcm_r, out_code_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = (cnt_r == '0);

  // Checks
  a_enc_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == urc_pkg::KIND_ENCODE |-> out_tlast)
    else $error("encode result without last mark");

  a_enc_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == urc_pkg::KIND_ENCODE |-> out_tdata[7:0] != '0)
    else $error("encode result carries the all-zero code");

  a_copy_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && $stable(out_tdata) && out_tuser == urc_pkg::KIND_DECODE)
    else $error("decode copy run broken");

  a_group_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == urc_pkg::KIND_ENCODE
      && !in_tuser[1] && fill_r == LAST_FILL |=> fill_r == '0 && sum_r == '0)
    else $error("group state not cleared on completion");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !out_free |=> a_valid_r && $stable(a_sum_r) && $stable(a_code_r))
    else $error("pending item lost from the input register");

endmodule

### test/ulaw_rate_codec_test.sv
// ----------------------------------------------------------------------------
// ulaw_rate_codec_test: self-checking bench for the mu-law rate codec
// Drives encode and decode requests through the input stream and predicts
// every result in the bench. Each result from the output stream is checked
// field by field against the oldest prediction. Both streams are throttled
// in random bursts, and the downlink gain is swept across its extremes.
// ----------------------------------------------------------------------------
module ulaw_rate_codec_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATIO      = urc_pkg::RATE_RATIO_DEF;
  localparam int HALF_CYCLE = 6;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int RANDOM_N   = 450;

  typedef struct packed {
    logic       first;
    logic       kind;
    logic [7:0] code;
    logic [15:0] pcm;
  } codec_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [15:0] pcm;
    logic        last;
  } codec_res_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [urc_pkg::DATA_W-1:0]  in_tdata   = '0;  // pcm_sample[15:0], code_byte[23:16]
  logic [urc_pkg::IUSER_W-1:0] in_tuser   = '0;  // kind[0], block_first[1]
  logic                        out_tvalid;
  logic                        out_tready = 1'b1;
  logic [urc_pkg::DATA_W-1:0]  out_tdata;        // code_out[7:0], pcm_out[23:8]
  logic                        out_tuser;        // result_kind
  logic                        out_tlast;        // last_copy
  logic                        cfg_we     = 1'b0;
  logic [urc_pkg::GAIN_W-1:0]  cfg_wdata  = '0;

  // Bench copy of the codec state
  int                         grp_sum;
  int                         grp_fill;
  logic [urc_pkg::GAIN_W-1:0] gain_now;
  codec_res_t                 results_due[$];
  int                         fails;
  bit                         idle_en;
  int                         send_calm;

  ulaw_rate_codec #(.RATE_RATIO(RATIO)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #(HALF_CYCLE) clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] ulaw_of(int avg);
    int unsigned mag;
    int unsigned seg_idx;
    int unsigned expo;
    logic [7:0]  sgn;
    logic [7:0]  code;
    sgn = (avg < 0) ? 8'h80 : 8'h00;
    mag = (avg < 0) ? -avg : avg;
    if (mag > urc_pkg::MU_CLIP) mag = urc_pkg::MU_CLIP;
    mag += urc_pkg::MU_BIAS;
    seg_idx = (mag >> 7) & 8'hFF;
    expo = 0;
    while (seg_idx > 1) begin
      seg_idx >>= 1;
      expo++;
    end
    code = ~(8'(sgn | (expo << 4) | ((mag >> (expo + 3)) & urc_pkg::MANT_MASK)));
    if (code == 8'h00) code = urc_pkg::MU_ZERO_SUB;
    return code;
  endfunction

  // The segment start 132 * (2^e - 1) folds into one shift with the mantissa.
  function automatic int ulaw_level(logic [7:0] code);
    logic [7:0] b;
    int         v;
    b = ~code;
    v = ((2 * int'(b[3:0]) + 33) << (int'(b[6:4]) + 2)) - 132;
    return b[7] ? -v : v;
  endfunction

  function automatic void codec_predict(codec_req_t r);
    codec_res_t res;
    int         avg;
    int         level;
    if (r.kind == urc_pkg::KIND_ENCODE) begin
      if (r.first) begin
        grp_sum  = 0;
        grp_fill = 0;
      end
      grp_sum += int'($signed(r.pcm));
      grp_fill++;
      if (grp_fill == RATIO) begin
        avg      = grp_sum / RATIO;
        grp_sum  = 0;
        grp_fill = 0;
        res.kind = urc_pkg::KIND_ENCODE;
        res.code = ulaw_of(avg);
        res.pcm  = '0;
        res.last = 1'b1;
        results_due.push_back(res);
      end
    end else begin
      level = ulaw_level(r.code) * int'(gain_now);
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      for (int k = 0; k < RATIO; k++) begin
        res.kind = urc_pkg::KIND_DECODE;
        res.code = '0;
        res.pcm  = 16'(level);
        res.last = (k == RATIO - 1);
        results_due.push_back(res);
      end
    end
  endfunction

  // Result checker: values are read in the active region, before any update
  // made at this edge.
  always @(posedge clk) begin : result_check
    codec_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0b data %h", out_tuser, out_tdata);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.kind) begin
          $error("result_kind: expected %0b, got %0b", want.kind, out_tuser);
          fails++;
        end
        if (out_tdata[7:0] !== want.code) begin
          $error("code_out: expected %h, got %h", want.code, out_tdata[7:0]);
          fails++;
        end
        if (out_tdata[23:8] !== want.pcm) begin
          $error("pcm_out: expected %0d, got %0d", $signed(want.pcm),
                 $signed(out_tdata[23:8]));
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last_copy: expected %0b, got %0b", want.last, out_tlast);
          fails++;
        end
      end
    end
  end

  // Back-pressure on the output: stall bursts mixed with calm stretches.
  always @(posedge clk) begin : sink_pacing
    int stall_left;
    int calm_left;
    if (!rst_n || !idle_en) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(20, 80);
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Presents one request and returns at the edge where it is taken. The
  // valid is left high so that back-to-back requests need no second drive.
  task automatic send_req(codec_req_t r);
    int gap;
    if (idle_en) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        send_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 15);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.code, r.pcm};
    in_tuser  <= {r.first, r.kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    codec_predict(r);
  endtask

  task automatic enc(logic [15:0] pcm, logic first);
    send_req('{first: first, kind: urc_pkg::KIND_ENCODE, code: 8'($urandom), pcm: pcm});
  endtask

  task automatic dec(logic [7:0] code, logic first);
    send_req('{first: first, kind: urc_pkg::KIND_DECODE, code: code, pcm: 16'($urandom)});
  endtask

  // Lets every pending result out, then idles on briefly in case a lone
  // sample without a result is still in flight.
  task automatic settle_codec();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (results_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic set_gain(logic [urc_pkg::GAIN_W-1:0] g);
    settle_codec();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gain_now = g;
  endtask

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n    <= 1'b1;
    grp_sum  = 0;
    grp_fill = 0;
    gain_now = urc_pkg::GAIN_RESET;
  endtask

  // Full-scale groups, the clipped most negative value and rounding of the
  // average towards zero.
  task automatic test_encode_extremes();
    enc(16'h7FFF, 1'b1);
    enc(16'h7FFF, 1'b0);
    enc(16'h8000, 1'b1);
    enc(16'h8000, 1'b0);
    enc(16'h0000, 1'b0);
    enc(16'h0000, 1'b0);
    enc(16'hFFFF, 1'b0);
    enc(16'h0000, 1'b0);
    enc(16'hFFFD, 1'b0);
    enc(16'h0000, 1'b0);
  endtask

  // A block mark drops the half-filled group; on a decode it is ignored.
  task automatic test_block_marks();
    enc(16'd1000, 1'b1);
    enc(16'd5, 1'b1);
    enc(16'd7, 1'b0);
    enc(16'd100, 1'b1);
    dec(8'h55, 1'b1);
    enc(16'd200, 1'b0);
  endtask

  task automatic test_decode_codes();
    dec(8'h00, 1'b0);
    dec(8'h7F, 1'b0);
    dec(8'h80, 1'b0);
    dec(8'hFF, 1'b0);
  endtask

  task automatic test_gain_extremes();
    set_gain(5'd0);
    dec(8'h00, 1'b0);
    dec(8'h80, 1'b0);
    set_gain(5'd1);
    dec(8'h00, 1'b0);
    dec(8'h9A, 1'b0);
    set_gain(5'd16);
    dec(8'h00, 1'b0);
    dec(8'hE7, 1'b0);
    set_gain(5'd31);
    dec(8'h80, 1'b0);
    dec(8'hF3, 1'b0);
  endtask

  function automatic logic [15:0] pick_pcm();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2:    return 16'(int'($urandom_range(0, 600)) - 300);
      3:       return 16'(int'($urandom_range(0, 8000)) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly complete groups and decodes, with stray samples and marks mixed
  // in. The last phase runs without any idling.
  task automatic test_random_traffic();
    int sent;
    int phase;
    int pick;
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_gain(5'($urandom_range(1, 16)));
        1:       set_gain(5'($urandom_range(0, 31)));
        2:       set_gain(5'($urandom_range(1, 16)));
        default: set_gain(urc_pkg::GAIN_RESET);
      endcase
      if (phase == 3) idle_en = 1'b0;
      while (sent < RANDOM_N * (phase + 1) / 4) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          for (int k = 0; k < RATIO; k++) begin
            enc(pick_pcm(), (k == 0) ? ($urandom_range(0, 3) == 0) : 1'b0);
            sent++;
          end
        end else if (pick < 17) begin
          dec(8'($urandom), 1'($urandom));
          sent++;
        end else begin
          enc(pick_pcm(), 1'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    fails     = 0;
    idle_en   = 1'b1;
    send_calm = 0;
    do_reset();
    test_encode_extremes();
    test_block_marks();
    test_decode_codes();
    test_gain_extremes();
    test_random_traffic();
    settle_codec();
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/urc_pkg.sv
hdl/ulaw_rate_codec.sv
test/ulaw_rate_codec_test.sv
